/* rtl/nearest_star_pick_unit_macros.svh */
// assertion macros for the nearest star pick unit checker
// depends on a clock named clock and a reset named reset in the using scope
`ifndef NEAREST_STAR_PICK_UNIT_MACROS_SVH
`define NEAREST_STAR_PICK_UNIT_MACROS_SVH

// same-cycle implication, off while reset is high
`define NSP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define NSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/nsp_pkg.sv */
// shared constants and types of the nearest star pick unit
// no dependencies
package nsp_pkg;

   // default table depth
   localparam int MAX_STARS_DEF = 64;

   // field widths
   localparam int COORD_W    = 17;
   localparam int CLICK_W    = 12;
   localparam int ENTRY_W    = 6;
   localparam int BUTTON_W   = 3;
   localparam int MODE_W     = 2;
   localparam int COUNT_W    = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // arithmetic widths: click in star format, difference, magnitude, square, sum
   localparam int FRAC_W = 4;
   localparam int FIX_W  = CLICK_W + FRAC_W;
   localparam int DIFF_W = COORD_W + 1;
   localparam int MAG_W  = COORD_W;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int DIST_W = SQ_W + 1;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVENT = 1'b1;

   // report modes
   localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STAR  = 2'd2;

   // result kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_STAR  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_REPORT_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STAR_COUNT  = 1'd1;

   // the only button acted on
   localparam logic [BUTTON_W-1:0] ACT_BUTTON = 3'd1;

   // control that travels with each star through the scan pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } scan_tag_type;

endpackage

/* rtl/nearest_star_pick_unit.sv */
// Nearest star pick unit: keeps a table of star positions (signed, 4 fraction
// bits) written one entry per write beat, and answers a press of button 1
// with either the click position (pixel mode) or the index of the nearest of
// the first star_count stars (at most the table depth) by squared distance,
// lower index on a tie; other modes give no result. A write beat, or an
// event that is not acted on, does not stall the input. A pixel click passes
// the pending result register, then the result register. In a star click
// the table RAM is read one star per cycle through its single port, each
// star passes the shared two-stage distance unit, and the running minimum
// closes the scan. With no stars there is no result. The input is stalled
// while a click is being worked on. Depends on nsp_pkg, nsp_ram and nsp_dist.
module nearest_star_pick_unit #(
   parameter int MAX_STARS = nsp_pkg::MAX_STARS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [nsp_pkg::ENTRY_W-1:0]         req_entry_index,
   input  logic signed [nsp_pkg::COORD_W-1:0]  req_star_x,
   input  logic signed [nsp_pkg::COORD_W-1:0]  req_star_y,
   input  logic                                req_is_press,
   input  logic [nsp_pkg::BUTTON_W-1:0]        req_button,
   input  logic [nsp_pkg::CLICK_W-1:0]         req_click_x,
   input  logic [nsp_pkg::CLICK_W-1:0]         req_click_y,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_kind,
   output logic [nsp_pkg::CLICK_W-1:0]         rsp_pixel_x,
   output logic [nsp_pkg::CLICK_W-1:0]         rsp_pixel_y,
   output logic [nsp_pkg::ENTRY_W-1:0]         rsp_star_index,
   // configuration port
   input  logic                                csr_we,
   input  logic [nsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [nsp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W  = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;
   localparam int WORD_W = 2 * nsp_pkg::COORD_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type                      state_ff, state_in;
   logic [nsp_pkg::MODE_W-1:0]     report_mode_ff, report_mode_in;
   logic [nsp_pkg::COUNT_W-1:0]    star_count_ff, star_count_in;

   // scan control
   logic                           issue_ff, issue_in;
   logic                           first_ff, first_in;
   logic [IDX_W-1:0]               addr_ff, addr_in;
   logic [IDX_W-1:0]               last_addr_ff, last_addr_in;
   logic [nsp_pkg::FIX_W-1:0]      click_fx_ff, click_fx_in;
   logic [nsp_pkg::FIX_W-1:0]      click_fy_ff, click_fy_in;
   nsp_pkg::scan_tag_type          ram_tag_ff, ram_tag_in;
   logic [IDX_W-1:0]               ram_idx_ff;

   // running minimum
   logic [nsp_pkg::DIST_W-1:0]     best_ff, best_in;
   logic [IDX_W-1:0]               best_idx_ff, best_idx_in;

   // pending result and output register
   logic                           res_kind_ff, res_kind_in;
   logic [nsp_pkg::CLICK_W-1:0]    res_px_ff, res_px_in;
   logic [nsp_pkg::CLICK_W-1:0]    res_py_ff, res_py_in;
   logic [nsp_pkg::ENTRY_W-1:0]    res_idx_ff, res_idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_kind_ff, rsp_kind_in;
   logic [nsp_pkg::CLICK_W-1:0]    rsp_px_ff, rsp_px_in;
   logic [nsp_pkg::CLICK_W-1:0]    rsp_py_ff, rsp_py_in;
   logic [nsp_pkg::ENTRY_W-1:0]    rsp_idx_ff, rsp_idx_in;

   logic                           req_take;
   logic                           is_click;
   logic                           write_ok;
   logic [31:0]                    count_wide;
   logic [IDX_W-1:0]               count_last;
   logic                           out_free;
   logic                           ram_we;
   logic [IDX_W-1:0]               ram_addr;
   logic [WORD_W-1:0]              ram_wdata, ram_rdata;
   nsp_pkg::scan_tag_type          d_tag;
   logic [IDX_W-1:0]               d_idx;
   logic [nsp_pkg::SQ_W-1:0]       d_sq_x, d_sq_y;
   logic [nsp_pkg::DIST_W-1:0]     d_sum;
   logic                           better;
   logic [IDX_W-1:0]               win_idx;

   // handshake and decode of the input beat
   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign is_click   = (req_command == nsp_pkg::CMD_EVENT) && req_is_press
                     && (req_button == nsp_pkg::ACT_BUTTON);
   assign write_ok   = (req_command == nsp_pkg::CMD_WRITE)
                     && (32'(req_entry_index) < 32'(MAX_STARS));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // last scanned index, star count saturated to the table depth
   assign count_wide = 32'(star_count_ff);
   assign count_last = (count_wide > 32'(MAX_STARS)) ? IDX_W'(MAX_STARS - 1)
                                                     : IDX_W'(count_wide - 32'd1);

   // configuration writes
   always_comb begin
      report_mode_in = report_mode_ff;
      star_count_in  = star_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            nsp_pkg::REG_REPORT_MODE: report_mode_in = csr_wdata[nsp_pkg::MODE_W-1:0];
            nsp_pkg::REG_STAR_COUNT:  star_count_in  = csr_wdata[nsp_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // star table: write beats when idle, scan reads during the scan
   assign ram_we    = req_take && write_ok;
   assign ram_addr  = (state_ff == ST_SCAN) ? addr_ff : IDX_W'(req_entry_index);
   assign ram_wdata = {req_star_x, req_star_y};

   nsp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_STARS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // tag of the star whose table word arrives next cycle
   assign ram_tag_in.valid = issue_ff;
   assign ram_tag_in.last  = issue_ff && (addr_ff == last_addr_ff);

   nsp_dist #(
      .IDX_W (IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (ram_tag_ff),
      .in_idx   (ram_idx_ff),
      .star_x   (ram_rdata[WORD_W-1:nsp_pkg::COORD_W]),
      .star_y   (ram_rdata[nsp_pkg::COORD_W-1:0]),
      .click_fx (click_fx_ff),
      .click_fy (click_fy_ff),
      .out_tag  (d_tag),
      .out_idx  (d_idx),
      .sq_x     (d_sq_x),
      .sq_y     (d_sq_y)
   );

   // running minimum compare, first star always taken
   assign d_sum   = nsp_pkg::DIST_W'(d_sq_x) + nsp_pkg::DIST_W'(d_sq_y);
   assign better  = first_ff || (d_sum < best_ff);
   assign win_idx = better ? d_idx : best_idx_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      first_in     = first_ff;
      addr_in      = addr_ff;
      last_addr_in = last_addr_ff;
      click_fx_in  = click_fx_ff;
      click_fy_in  = click_fy_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      res_kind_in  = res_kind_ff;
      res_px_in    = res_px_ff;
      res_py_in    = res_py_ff;
      res_idx_in   = res_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_px_in    = rsp_px_ff;
      rsp_py_in    = rsp_py_ff;
      rsp_idx_in   = rsp_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && is_click) begin
               if (report_mode_ff == nsp_pkg::MODE_PIXEL) begin
                  res_kind_in = nsp_pkg::KIND_PIXEL;
                  res_px_in   = req_click_x;
                  res_py_in   = req_click_y;
                  res_idx_in  = '0;
                  state_in    = ST_HOLD;
               end else if ((report_mode_ff == nsp_pkg::MODE_STAR)
                            && (star_count_ff != '0)) begin
                  click_fx_in  = {req_click_x, {nsp_pkg::FRAC_W{1'b0}}};
                  click_fy_in  = {req_click_y, {nsp_pkg::FRAC_W{1'b0}}};
                  last_addr_in = count_last;
                  addr_in      = '0;
                  issue_in     = 1'b1;
                  first_in     = 1'b1;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue one table read per cycle
            if (issue_ff) begin
               addr_in = addr_ff + IDX_W'(1);
               if (addr_ff == last_addr_ff) begin
                  issue_in = 1'b0;
               end
            end
            // fold one distance per cycle into the minimum
            if (d_tag.valid) begin
               first_in    = 1'b0;
               best_in     = better ? d_sum : best_ff;
               best_idx_in = win_idx;
               if (d_tag.last) begin
                  res_kind_in = nsp_pkg::KIND_STAR;
                  res_px_in   = '0;
                  res_py_in   = '0;
                  res_idx_in  = nsp_pkg::ENTRY_W'(win_idx);
                  state_in    = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_px_in    = res_px_ff;
               rsp_py_in    = res_py_ff;
               rsp_idx_in   = res_idx_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         report_mode_ff <= '0;
         star_count_ff  <= '0;
         issue_ff       <= 1'b0;
         first_ff       <= 1'b0;
         ram_tag_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         report_mode_ff <= report_mode_in;
         star_count_ff  <= star_count_in;
         issue_ff       <= issue_in;
         first_ff       <= first_in;
         ram_tag_ff     <= ram_tag_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      last_addr_ff <= last_addr_in;
      click_fx_ff  <= click_fx_in;
      click_fy_ff  <= click_fy_in;
      ram_idx_ff   <= addr_ff;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      res_kind_ff  <= res_kind_in;
      res_px_ff    <= res_px_in;
      res_py_ff    <= res_py_in;
      res_idx_ff   <= res_idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_px_ff    <= rsp_px_in;
      rsp_py_ff    <= rsp_py_in;
      rsp_idx_ff   <= rsp_idx_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_pixel_x    = rsp_px_ff;
   assign rsp_pixel_y    = rsp_py_ff;
   assign rsp_star_index = rsp_idx_ff;

endmodule

/* rtl/nsp_ram.sv */
// generic single-port ram with registered read
// no dependencies
module nsp_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                           wdata,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/nsp_dist.sv */
// shared squared-distance unit: difference and magnitude, then squares
// depends on nsp_pkg
module nsp_dist #(
   parameter int IDX_W = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  nsp_pkg::scan_tag_type             in_tag,
   input  logic [IDX_W-1:0]                  in_idx,
   input  logic [nsp_pkg::COORD_W-1:0]       star_x,
   input  logic [nsp_pkg::COORD_W-1:0]       star_y,
   input  logic [nsp_pkg::FIX_W-1:0]         click_fx,
   input  logic [nsp_pkg::FIX_W-1:0]         click_fy,
   output nsp_pkg::scan_tag_type             out_tag,
   output logic [IDX_W-1:0]                  out_idx,
   output logic [nsp_pkg::SQ_W-1:0]          sq_x,
   output logic [nsp_pkg::SQ_W-1:0]          sq_y
);

   logic [nsp_pkg::DIFF_W-1:0] dx;
   logic [nsp_pkg::DIFF_W-1:0] dy;
   logic [nsp_pkg::MAG_W-1:0]  mag_x_in, mag_y_in;
   logic [nsp_pkg::MAG_W-1:0]  mag_x_ff, mag_y_ff;
   logic [nsp_pkg::SQ_W-1:0]   sq_x_in, sq_y_in;
   logic [nsp_pkg::SQ_W-1:0]   sq_x_ff, sq_y_ff;
   nsp_pkg::scan_tag_type      tag1_ff, tag2_ff;
   logic [IDX_W-1:0]           idx1_ff, idx2_ff;

   // signed difference in 18 bits, then magnitude
   assign dx = {star_x[nsp_pkg::COORD_W-1], star_x}
             - {{(nsp_pkg::DIFF_W - nsp_pkg::FIX_W){1'b0}}, click_fx};
   assign dy = {star_y[nsp_pkg::COORD_W-1], star_y}
             - {{(nsp_pkg::DIFF_W - nsp_pkg::FIX_W){1'b0}}, click_fy};
   assign mag_x_in = dx[nsp_pkg::DIFF_W-1] ? nsp_pkg::MAG_W'(-dx) : nsp_pkg::MAG_W'(dx);
   assign mag_y_in = dy[nsp_pkg::DIFF_W-1] ? nsp_pkg::MAG_W'(-dy) : nsp_pkg::MAG_W'(dy);

   // squares of the registered magnitudes
   assign sq_x_in = nsp_pkg::SQ_W'(mag_x_ff) * nsp_pkg::SQ_W'(mag_x_ff);
   assign sq_y_in = nsp_pkg::SQ_W'(mag_y_ff) * nsp_pkg::SQ_W'(mag_y_ff);

   // tag pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
      end
   end

   // data pipeline
   always_ff @(posedge clock) begin
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      idx1_ff  <= in_idx;
      sq_x_ff  <= sq_x_in;
      sq_y_ff  <= sq_y_in;
      idx2_ff  <= idx1_ff;
   end

   assign out_tag = tag2_ff;
   assign out_idx = idx2_ff;
   assign sq_x    = sq_x_ff;
   assign sq_y    = sq_y_ff;

endmodule

/* rtl/nsp_checker.sv */
// port-level checks of the nearest star pick unit, bound to the top level
// depends on nsp_pkg and nearest_star_pick_unit_macros.svh
`include "nearest_star_pick_unit_macros.svh"

module nsp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_command,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_kind,
   input logic [nsp_pkg::CLICK_W-1:0]         rsp_pixel_x,
   input logic [nsp_pkg::CLICK_W-1:0]         rsp_pixel_y,
   input logic [nsp_pkg::ENTRY_W-1:0]         rsp_star_index
);

   // a stalled result beat holds
   `NSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_star_index), "stalled result beat changed")

   // a table write never starts a busy period
   `NSP_ASSERT_NEXT(a_write_no_stall, req_valid && !req_stall && (req_command == nsp_pkg::CMD_WRITE), !req_stall, "input stalled after a write beat")

   // a new result comes from a busy period that has just ended
   `NSP_ASSERT_IMPL(a_rsp_after_busy, $rose(rsp_valid), $past(req_stall), "result appeared without a busy period")

   // the input opens again together with a new result
   `NSP_ASSERT_IMPL(a_rsp_frees_input, $rose(rsp_valid), !req_stall, "input still stalled when result appeared")

endmodule

bind nearest_star_pick_unit nsp_checker u_nsp_checker (.*);
